### hw/rtl/gsmfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmfs_pkg
// Shared constants and control types of the frame sync deframer.
// ----------------------------------------------------------------------------
package gsmfs_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 33;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned SIG_W    = 4;
  localparam int unsigned SPF_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 16;

  localparam logic [BYTE_W-1:0] SIG_MASK  = 8'hF0;
  localparam logic [SIG_W-1:0]  SIG_RESET = 4'd13;
  localparam logic [SPF_W-1:0]  SPF_RESET = 16'd160;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPF       = 1'b1;

  typedef struct packed {
    logic in_take;   // input byte transferred this cycle
    logic rd_en;     // read frame store at burst index
    logic out_take;  // output byte transferred this cycle
  } cmd_t;

  typedef struct packed {
    logic emit_req;  // the offered byte completes a frame to emit
    logic idx_last;  // burst index is on the final byte
  } sts_t;

endpackage

### hw/rtl/gsmfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmfs_ctrl
// Sequencer: takes bytes, then drains a finished frame one byte at a time.
// ----------------------------------------------------------------------------
module gsmfs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  gsmfs_pkg::sts_t sts_i,
  output gsmfs_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && sts_i.emit_req) state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready_i) state_q <= sts_i.idx_last ? S_IDLE : S_READ;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SHOW);

  always_comb begin
    cmd_o          = '0;
    cmd_o.in_take  = in_ready_o && in_valid_i;
    cmd_o.rd_en    = (state_q == S_READ);
    cmd_o.out_take = out_valid_o && out_ready_i;
  end

endmodule

### hw/rtl/gsmfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmfs_datapath
// Frame store, fill counter, sync flag, timestamp and configuration registers.
// ----------------------------------------------------------------------------
module gsmfs_datapath #(
  parameter int unsigned FRAME_BYTES = gsmfs_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsmfs_pkg::cmd_t                     cmd_i,
  output gsmfs_pkg::sts_t                     sts_o,
  input  logic [gsmfs_pkg::BYTE_W-1:0]        in_byte_i,
  input  logic                                cfg_we_i,
  input  logic [gsmfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gsmfs_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic [gsmfs_pkg::BYTE_W-1:0]        frame_byte_o,
  output logic [gsmfs_pkg::IDX_W-1:0]         byte_index_o,
  output logic [gsmfs_pkg::TS_W-1:0]          frame_timestamp_o,
  output logic                                last_of_frame_o
);

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);

  logic [gsmfs_pkg::BYTE_W-1:0] mem [FRAME_BYTES];
  logic [gsmfs_pkg::BYTE_W-1:0] rd_data_q;

  logic [CntW-1:0]              fill_q, fill_d;
  logic                         sync_q, sync_d;
  logic [gsmfs_pkg::TS_W-1:0]   ts_q, ts_d;
  logic [gsmfs_pkg::BYTE_W-1:0] pend_q, pend_d;
  logic                         pend_v_q, pend_v_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [gsmfs_pkg::SIG_W-1:0]  sig_q;
  logic [gsmfs_pkg::SPF_W-1:0]  spf_q;

  logic                         wr_en;
  logic [IdxW-1:0]              wr_addr;
  logic [gsmfs_pkg::BYTE_W-1:0] wr_data;

  logic sig_match, fill_zero, fill_full, fill_last, idx_last;

  assign sig_match = (in_byte_i & gsmfs_pkg::SIG_MASK) == {sig_q, 4'b0000};
  assign fill_zero = (fill_q == '0);
  assign fill_full = (fill_q == CntW'(FRAME_BYTES));
  assign fill_last = (fill_q == CntW'(FRAME_BYTES - 1));
  assign idx_last  = (idx_q == IdxW'(FRAME_BYTES - 1));

  // a synced frame completes, or the check byte after a hunted frame matches
  assign sts_o.emit_req = (fill_last && sync_q) || (fill_full && sig_match);
  assign sts_o.idx_last = idx_last;

  always_comb begin
    fill_d   = fill_q;
    sync_d   = sync_q;
    ts_d     = ts_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    idx_d    = idx_q;
    wr_en    = 1'b0;
    wr_addr  = fill_q[IdxW-1:0];
    wr_data  = in_byte_i;

    if (cmd_i.in_take) begin
      idx_d = '0;
      priority if (fill_zero) begin
        if (sig_match) begin
          wr_en  = 1'b1;
          fill_d = CntW'(1);
        end else begin
          sync_d = 1'b0;
        end
      end else if (!fill_full) begin
        wr_en  = 1'b1;
        fill_d = (fill_last && sync_q) ? '0 : fill_q + CntW'(1);
      end else begin
        // check byte after a collected frame
        if (sig_match) begin
          sync_d   = 1'b1;
          pend_d   = in_byte_i;
          pend_v_d = 1'b1;
        end else begin
          sync_d = 1'b0;
          fill_d = '0;
        end
      end
    end

    if (cmd_i.out_take) begin
      if (idx_last) begin
        ts_d = ts_q + {{(gsmfs_pkg::TS_W - gsmfs_pkg::SPF_W){1'b0}}, spf_q};
        if (pend_v_q) begin
          // check byte opens the next frame once the burst is out
          wr_en    = 1'b1;
          wr_addr  = '0;
          wr_data  = pend_q;
          fill_d   = CntW'(1);
          pend_v_d = 1'b0;
        end
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      sync_q   <= 1'b0;
      ts_q     <= '0;
      pend_v_q <= 1'b0;
      idx_q    <= '0;
      sig_q    <= gsmfs_pkg::SIG_RESET;
      spf_q    <= gsmfs_pkg::SPF_RESET;
    end else begin
      fill_q   <= fill_d;
      sync_q   <= sync_d;
      ts_q     <= ts_d;
      pend_v_q <= pend_v_d;
      idx_q    <= idx_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gsmfs_pkg::CFG_SIGNATURE: sig_q <= cfg_wdata_i[gsmfs_pkg::SIG_W-1:0];
          gsmfs_pkg::CFG_SPF:       spf_q <= cfg_wdata_i[gsmfs_pkg::SPF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem[idx_q];
  end

  assign frame_byte_o      = rd_data_q;
  assign byte_index_o      = gsmfs_pkg::IDX_W'(idx_q);
  assign frame_timestamp_o = ts_q;
  assign last_of_frame_o   = idx_last;

endmodule

### hw/rtl/gsm_frame_sync_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_frame_sync_deframer_top
// Finds GSM frame alignment in a byte stream and emits aligned frame bursts.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o   | in_byte_i
//  out     | out_valid_o / out_ready_i | frame_byte_o, byte_index_o,
//          |                           | frame_timestamp_o, last_of_frame_o
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
//  a byte that completes no frame leaves the input ready for the next; the
//  byte that completes one is followed by a burst of FRAME_BYTES bytes, each
//  read from the frame store in S_READ, registered, then offered in S_SHOW
//  no input is taken during a burst; output stalls simply hold the burst
//  reset clears sync, fill count and timestamp; frame store needs no clearing
module gsm_frame_sync_deframer_top #(
  parameter int unsigned FRAME_BYTES = gsmfs_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gsmfs_pkg::BYTE_W-1:0]    in_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gsmfs_pkg::BYTE_W-1:0]    frame_byte_o,
  output logic [gsmfs_pkg::IDX_W-1:0]     byte_index_o,
  output logic [gsmfs_pkg::TS_W-1:0]      frame_timestamp_o,
  output logic                            last_of_frame_o,
  input  logic                            cfg_we_i,
  input  logic [gsmfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gsmfs_pkg::CFG_W-1:0]     cfg_wdata_i
);

  gsmfs_pkg::cmd_t cmd;
  gsmfs_pkg::sts_t sts;

  gsmfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gsmfs_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_byte_i         (in_byte_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .frame_byte_o      (frame_byte_o),
    .byte_index_o      (byte_index_o),
    .frame_timestamp_o (frame_timestamp_o),
    .last_of_frame_o   (last_of_frame_o)
  );

endmodule

### hw/rtl/gsmfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmfs_checker
// Port-level checks of the deframer's burst behavior.
// ----------------------------------------------------------------------------
module gsmfs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [gsmfs_pkg::BYTE_W-1:0]    frame_byte_o,
  input logic [gsmfs_pkg::IDX_W-1:0]     byte_index_o,
  input logic [gsmfs_pkg::TS_W-1:0]      frame_timestamp_o,
  input logic                            last_of_frame_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o && out_ready_i;

  // input is never taken while a burst byte is offered
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready during burst");

  // burst keeps going until its last byte
  a_burst_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_of_frame_o |=> !in_ready_o)
    else $error("burst ended early");

  // next byte of a burst follows with index up by one and same timestamp
  a_next_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_of_frame_o |-> ##2
      (out_valid_o && byte_index_o == $past(byte_index_o, 2) + 6'd1 &&
       frame_timestamp_o == $past(frame_timestamp_o, 2)))
    else $error("burst sequence broken");

  // stalled output holds its byte
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o) &&
      $stable(byte_index_o))
    else $error("stalled output changed");

endmodule

bind gsm_frame_sync_deframer_top gsmfs_checker u_gsmfs_checker (.*);
